FILE: hdl/ftcl_pkg.sv
`default_nettype none

package ftcl_pkg;

  // Run phases as reported in run_state.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_RUNNING = 3'd1;
  localparam logic [2:0] PH_DONE    = 3'd2;
  localparam logic [2:0] PH_STOPPED = 3'd3;
  localparam logic [2:0] PH_FAILED  = 3'd4;

  // Request kinds.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_POLL  = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_CLOCK   = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  localparam int IN_W  = 128;
  localparam int OUT_W = 232;

  // One stored record, as held in the record memory.
  typedef struct packed {
    logic [31:0] clock_word;
    logic [31:0] tick;
    logic [10:0] frame_second;
    logic [10:0] frame_first;
  } rec_t;

  // Status reported with every item.
  typedef struct packed {
    logic [2:0]  run_state;
    logic        error_code;
    logic [6:0]  record_count;
    logic [31:0] poll_total;
    logic [31:0] crossed_total;
    logic [31:0] duplicate_total;
    logic [31:0] elapsed_ticks;
    logic        trace_valid;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/ftcl_store.sv
`default_nettype none

module ftcl_store #(
  parameter int RECORD_DEPTH = 64,
  localparam int AW = $clog2(RECORD_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire ftcl_pkg::rec_t  wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output      ftcl_pkg::rec_t  rd_data
);
  import ftcl_pkg::*;

  rec_t mem [RECORD_DEPTH];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/ftcl_ctrl.sv
`default_nettype none

module ftcl_ctrl #(
  parameter int RECORD_DEPTH = 64,
  localparam int AW = $clog2(RECORD_DEPTH),
  localparam int CW = $clog2(RECORD_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic [1:0]         req,
  input  wire logic [31:0]        now_ms,
  input  wire ftcl_pkg::rec_t     rec,
  input  wire logic [5:0]         trace_index,
  input  wire logic [31:0]        timeout_limit,
  output      ftcl_pkg::status_t  stat_nxt,
  output      logic               wr_en,
  output      logic [AW-1:0]      wr_addr,
  output      logic [AW-1:0]      rd_addr
);
  import ftcl_pkg::*;

  logic [2:0]    phase_r, phase_nxt;
  logic          fault_r, fault_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   polls_r, polls_nxt;
  logic [31:0]   cross_r, cross_nxt;
  logic [31:0]   dup_r, dup_nxt;
  logic [31:0]   begin_r, begin_nxt;
  logic [31:0]   elapsed_r, elapsed_nxt;
  logic          seen_r, seen_nxt;
  logic [31:0]   last_r, last_nxt;

  logic [31:0]   elapsed_calc;
  logic          timed_out;
  logic          is_dup;
  logic          store_ok;

  assign elapsed_calc = now_ms - begin_r;
  assign timed_out    = (elapsed_calc >= timeout_limit);
  assign is_dup       = (!seen_r && rec.tick == 32'd0) || (seen_r && rec.tick == last_r);
  assign store_ok     = (count_r < CW'(RECORD_DEPTH));

  always_comb begin
    phase_nxt   = phase_r;
    fault_nxt   = fault_r;
    count_nxt   = count_r;
    polls_nxt   = polls_r;
    cross_nxt   = cross_r;
    dup_nxt     = dup_r;
    begin_nxt   = begin_r;
    elapsed_nxt = elapsed_r;
    seen_nxt    = seen_r;
    last_nxt    = last_r;
    wr_en       = 1'b0;
    unique case (req)
      REQ_START: begin
        if (phase_r != PH_RUNNING) begin
          count_nxt   = '0;
          polls_nxt   = '0;
          cross_nxt   = '0;
          dup_nxt     = '0;
          elapsed_nxt = '0;
          seen_nxt    = 1'b0;
          begin_nxt   = now_ms;
          fault_nxt   = 1'b0;
          phase_nxt   = PH_RUNNING;
        end
      end
      REQ_POLL: begin
        if (phase_r == PH_RUNNING) begin
          elapsed_nxt = elapsed_calc;
          if (timed_out) begin
            phase_nxt = PH_FAILED;
            fault_nxt = 1'b1;
          end else begin
            polls_nxt = polls_r + 32'd1;
            if (rec.frame_first != rec.frame_second) begin
              cross_nxt = cross_r + 32'd1;
            end
            if (is_dup) begin
              dup_nxt = dup_r + 32'd1;
            end else begin
              if (store_ok) begin
                wr_en     = fire;
                count_nxt = count_r + 1'b1;
              end
              seen_nxt = 1'b1;
              last_nxt = rec.tick;
              // Full once this record fills the last free entry.
              if (count_r >= CW'(RECORD_DEPTH - 1)) begin
                phase_nxt = PH_DONE;
                fault_nxt = 1'b0;
              end
            end
          end
        end
      end
      REQ_STOP: begin
        if (phase_r == PH_RUNNING) begin
          phase_nxt = PH_STOPPED;
          fault_nxt = 1'b0;
        end
      end
      REQ_READ: begin
      end
      default: begin
      end
    endcase
  end

  assign wr_addr = count_r[AW-1:0];
  assign rd_addr = AW'(trace_index);

  always_comb begin
    stat_nxt.run_state       = phase_nxt;
    stat_nxt.error_code      = fault_nxt;
    stat_nxt.record_count    = 7'(count_nxt);
    stat_nxt.poll_total      = polls_nxt;
    stat_nxt.crossed_total   = cross_nxt;
    stat_nxt.duplicate_total = dup_nxt;
    stat_nxt.elapsed_ticks   = elapsed_nxt;
    stat_nxt.trace_valid     = (req == REQ_READ) && (32'(trace_index) < 32'(count_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      fault_r   <= 1'b0;
      count_r   <= '0;
      polls_r   <= '0;
      cross_r   <= '0;
      dup_r     <= '0;
      begin_r   <= '0;
      elapsed_r <= '0;
      seen_r    <= 1'b0;
      last_r    <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      fault_r   <= fault_nxt;
      count_r   <= count_nxt;
      polls_r   <= polls_nxt;
      cross_r   <= cross_nxt;
      dup_r     <= dup_nxt;
      begin_r   <= begin_nxt;
      elapsed_r <= elapsed_nxt;
      seen_r    <= seen_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ftcl_out.sv
`default_nettype none

module ftcl_out (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire ftcl_pkg::status_t             stat_in,
  input  wire ftcl_pkg::rec_t                rd_data,
  output      logic                          can_take,
  input  wire logic                          out_tready,
  output      logic                          out_tvalid,
  output      logic [ftcl_pkg::OUT_W-1:0]    out_tdata,
  output      logic                          out_tuser
);
  import ftcl_pkg::*;

  logic             s1_valid_r;
  status_t          s1_stat_r;
  logic             o_valid_r;
  logic [OUT_W-1:0] o_data_r;
  logic             o_user_r;
  logic             adv;
  rec_t             rec_shown;
  logic [OUT_W-1:0] packed_data;

  assign adv      = s1_valid_r && (!o_valid_r || out_tready);
  assign can_take = !s1_valid_r || !o_valid_r || out_tready;

  // Trace fields read as zero unless the index named a stored record.
  assign rec_shown = s1_stat_r.trace_valid ? rd_data : '0;

  assign packed_data = {7'd0, rec_shown.clock_word, rec_shown.frame_second, rec_shown.tick,
                        rec_shown.frame_first, s1_stat_r.elapsed_ticks,
                        s1_stat_r.duplicate_total, s1_stat_r.crossed_total,
                        s1_stat_r.poll_total, s1_stat_r.record_count,
                        s1_stat_r.error_code, s1_stat_r.run_state};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        o_valid_r <= 1'b1;
      end else if (out_tready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_stat_r <= stat_in;
    end
    if (adv) begin
      o_data_r <= packed_data;
      o_user_r <= s1_stat_r.trace_valid;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_user_r;

endmodule

`default_nettype wire

FILE: hdl/frame_timestamp_capture_log_top.sv
`default_nettype none

// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_tvalid / in_tready  | in_tdata 128 bits, in_tuser 2 bits
// out_     | output    | out_tvalid / out_tready| out_tdata 232 bits, out_tuser 1 bit
// cfg_     | APB       | psel, penable, pready  | 32-bit registers at 0x0 and 0x4
//
// One item is accepted per cycle unless both stages hold items and the output stalls.
// The accepting edge updates the control registers and reads the record memory
// into the middle stage; the output register is loaded from it once it can advance.
// Reset is synchronous and active low; it clears the run state, the counters and
// the pipeline valids. The record memory is not cleared, and never needs to be,
// since only entries written in the current run are ever returned.
// A stalled output holds its item while one more item waits in the middle stage.

module frame_timestamp_capture_log_top #(
  parameter int RECORD_DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Fields from bit 0: now_ms[31:0], frame_first[42:32], capture_tick[74:43],
  // frame_second[85:75], clock_word[117:86], trace_index[123:118], zero padding.
  input  wire logic [ftcl_pkg::IN_W-1:0]    in_tdata,
  // Fields from bit 0: req_type[1:0].
  input  wire logic [1:0]                   in_tuser,
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  // Fields from bit 0: run_state[2:0], error_code[3], record_count[10:4],
  // poll_total[42:11], crossed_total[74:43], duplicate_total[106:75],
  // elapsed_ticks[138:107], trace_frame_first[149:139], trace_tick[181:150],
  // trace_frame_second[192:182], trace_clock[224:193], zero padding.
  output      logic [ftcl_pkg::OUT_W-1:0]   out_tdata,
  // Fields from bit 0: trace_valid[0].
  output      logic                         out_tuser,
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [2:0]                   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output      logic [31:0]                  cfg_prdata,
  output      logic                         cfg_pready
);
  import ftcl_pkg::*;

  localparam int AW = $clog2(RECORD_DEPTH);

  logic [31:0]   timeout_limit_r;
  logic          clock_mode_r;
  logic          cfg_wr;
  logic          fire;
  logic          can_take;
  rec_t          rec_in;
  status_t       stat_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  rec_t          rd_data;

  // Configuration port. The clock mode is held for software only.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= TIMEOUT_RESET;
      clock_mode_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_TIMEOUT: timeout_limit_r <= cfg_pwdata;
        REG_CLOCK:   clock_mode_r    <= cfg_pwdata[0];
        default:     timeout_limit_r <= timeout_limit_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_TIMEOUT: cfg_prdata = timeout_limit_r;
      REG_CLOCK:   cfg_prdata = {31'd0, clock_mode_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // Input item fields.
  assign rec_in.frame_first  = in_tdata[42:32];
  assign rec_in.tick         = in_tdata[74:43];
  assign rec_in.frame_second = in_tdata[85:75];
  assign rec_in.clock_word   = in_tdata[117:86];

  assign in_tready = can_take;
  assign fire      = in_tvalid && in_tready;

  ftcl_ctrl #(.RECORD_DEPTH(RECORD_DEPTH)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .req           (in_tuser),
    .now_ms        (in_tdata[31:0]),
    .rec           (rec_in),
    .trace_index   (in_tdata[123:118]),
    .timeout_limit (timeout_limit_r),
    .stat_nxt      (stat_nxt),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr)
  );

  // Every accepted item reads the entry its trace index names; the output
  // stage zeroes the fields unless the read was a valid trace read.
  ftcl_store #(.RECORD_DEPTH(RECORD_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (rec_in),
    .rd_en   (fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ftcl_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .stat_in    (stat_nxt),
    .rd_data    (rd_data),
    .can_take   (can_take),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: hdl/ftcl_checker.sv
`default_nettype none

module ftcl_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [ftcl_pkg::OUT_W-1:0] out_tdata,
  input wire logic                       out_tuser
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // With the output register empty the block always has room for an item.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with empty output");

  // Trace fields are zero unless the result carries a stored record.
  a_trace_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[224:139] == '0)
    else $error("trace fields set without a record");

endmodule

bind frame_timestamp_capture_log_top ftcl_checker u_ftcl_checker (.*);

`default_nettype wire

FILE: test/tb_frame_timestamp_capture_log_top.sv
`timescale 1ns / 100ps

module tb_frame_timestamp_capture_log_top;
  import ftcl_pkg::*;

  localparam int DEPTH = 64;

  // Everything one status item carries, laid out field by field so that a
  // mismatch can be reported under the field's own name.
  typedef struct {
    logic [2:0]  run_state;
    logic        error_code;
    logic [6:0]  record_count;
    logic [31:0] poll_total;
    logic [31:0] crossed_total;
    logic [31:0] duplicate_total;
    logic [31:0] elapsed_ticks;
    logic        trace_valid;
    logic [10:0] trace_frame_first;
    logic [31:0] trace_tick;
    logic [10:0] trace_frame_second;
    logic [31:0] trace_clock;
  } status_word_t;

  // The scoreboard keeps its own copy of the capture log: run phase, counters,
  // the stored records and both registers. Every accepted request item is
  // played against that copy, and the status it should produce is queued.
  class capture_log_board;
    logic [31:0]  limit_ms;
    logic         clock_sel;
    logic [2:0]   run_phase;
    logic         timed_out;
    logic [6:0]   records;
    logic [31:0]  polls;
    logic [31:0]  crossings;
    logic [31:0]  repeats;
    logic [31:0]  run_begin_ms;
    logic [31:0]  elapsed;
    bit           tick_noted;
    logic [31:0]  prev_tick;
    rec_t         log_mem [DEPTH];
    status_word_t status_due [$];
    int           errors;

    function new();
      limit_ms     = TIMEOUT_RESET;
      clock_sel    = 1'b0;
      run_phase    = PH_IDLE;
      timed_out    = 1'b0;
      records      = '0;
      polls        = '0;
      crossings    = '0;
      repeats      = '0;
      run_begin_ms = '0;
      elapsed      = '0;
      tick_noted   = 0;
      prev_tick    = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic sel, logic [31:0] value);
      if (sel == REG_TIMEOUT) begin
        limit_ms = value;
      end else begin
        clock_sel = value[0];
      end
    endfunction

    function void note_request(logic [1:0] req, logic [31:0] now, logic [10:0] f1,
                               logic [31:0] tick, logic [10:0] f2, logic [31:0] cw,
                               logic [5:0] idx);
      status_word_t e;
      case (req)
        REQ_START: begin
          // A start that arrives mid-run is refused outright.
          if (run_phase != PH_RUNNING) begin
            records      = '0;
            polls        = '0;
            crossings    = '0;
            repeats      = '0;
            elapsed      = '0;
            tick_noted   = 0;
            run_begin_ms = now;
            timed_out    = 1'b0;
            run_phase    = PH_RUNNING;
          end
        end
        REQ_POLL: begin
          if (run_phase == PH_RUNNING) begin
            elapsed = now - run_begin_ms;
            if (elapsed >= limit_ms) begin
              run_phase = PH_FAILED;
              timed_out = 1'b1;
            end else begin
              polls = polls + 1;
              if (f1 != f2) crossings = crossings + 1;
              if ((!tick_noted && tick == '0) || (tick_noted && tick == prev_tick)) begin
                repeats = repeats + 1;
              end else begin
                if (records < DEPTH) begin
                  log_mem[records].frame_first  = f1;
                  log_mem[records].frame_second = f2;
                  log_mem[records].tick         = tick;
                  log_mem[records].clock_word   = cw;
                  records = records + 7'd1;
                end
                tick_noted = 1;
                prev_tick  = tick;
                if (records >= DEPTH) begin
                  run_phase = PH_DONE;
                  timed_out = 1'b0;
                end
              end
            end
          end
        end
        REQ_STOP: begin
          if (run_phase == PH_RUNNING) begin
            run_phase = PH_STOPPED;
            timed_out = 1'b0;
          end
        end
        default: ;
      endcase

      e.run_state          = run_phase;
      e.error_code         = timed_out;
      e.record_count       = records;
      e.poll_total         = polls;
      e.crossed_total      = crossings;
      e.duplicate_total    = repeats;
      e.elapsed_ticks      = elapsed;
      e.trace_valid        = 1'b0;
      e.trace_frame_first  = '0;
      e.trace_tick         = '0;
      e.trace_frame_second = '0;
      e.trace_clock        = '0;
      if (req == REQ_READ && idx < records) begin
        e.trace_valid        = 1'b1;
        e.trace_frame_first  = log_mem[idx].frame_first;
        e.trace_tick         = log_mem[idx].tick;
        e.trace_frame_second = log_mem[idx].frame_second;
        e.trace_clock        = log_mem[idx].clock_word;
      end
      status_due.push_back(e);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_status(logic [OUT_W-1:0] d, logic tv);
      status_word_t e;
      if (status_due.size() == 0) begin
        $error("status item arrived with no request outstanding");
        errors++;
        return;
      end
      e = status_due.pop_front();
      compare("run_state", e.run_state, d[2:0]);
      compare("error_code", e.error_code, d[3]);
      compare("record_count", e.record_count, d[10:4]);
      compare("poll_total", e.poll_total, d[42:11]);
      compare("crossed_total", e.crossed_total, d[74:43]);
      compare("duplicate_total", e.duplicate_total, d[106:75]);
      compare("elapsed_ticks", e.elapsed_ticks, d[138:107]);
      compare("trace_valid", e.trace_valid, tv);
      compare("trace_frame_first", e.trace_frame_first, d[149:139]);
      compare("trace_tick", e.trace_tick, d[181:150]);
      compare("trace_frame_second", e.trace_frame_second, d[192:182]);
      compare("trace_clock", e.trace_clock, d[224:193]);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [IN_W-1:0]   in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              in_tvalid = 1'b0;
  wire               in_tready;
  wire  [OUT_W-1:0]  out_tdata;
  wire               out_tuser;
  wire               out_tvalid;
  logic              out_tready = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  wire  [31:0]       cfg_prdata;
  wire               cfg_pready;

  // Percentages of cycles in which the sender holds back an item and in which
  // the receiver refuses one; the main sequence changes them between phases.
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 54;

  capture_log_board board;

  frame_timestamp_capture_log_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // The receiver decides afresh at every falling edge whether it will take an
  // item at the next rising edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result items are sampled at the rising edge at which they are accepted.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_status(out_tdata, out_tuser);
  end

  // Random values at the widths of a frame number and of a trace index.
  function automatic logic [10:0] rnd_frame();
    return 11'($urandom);
  endfunction

  function automatic logic [5:0] rnd_index();
    return 6'($urandom);
  endfunction

  // Offers one request item, with random idle cycles ahead of it, and hands it
  // to the scoreboard at the edge where it is taken. Fields are packed from
  // bit 0 upwards: now_ms, frame_first, capture_tick, frame_second,
  // clock_word, trace_index.
  task automatic send_item(input logic [1:0] req, input logic [31:0] now,
                           input logic [10:0] f1, input logic [31:0] tick,
                           input logic [10:0] f2, input logic [31:0] cw,
                           input logic [5:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, idx, cw, f2, tick, f1, now};
    do @(posedge clk); while (!in_tready);
    board.note_request(req, now, f1, tick, f2, cw, idx);
  endtask

  // Holds the input back until every outstanding status item has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.status_due.size() != 0) @(posedge clk);
  endtask

  // Writes one register over the configuration port and reads it straight
  // back. Only ever called while the block has nothing in flight.
  task automatic program_reg(input logic sel, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(sel, value);
    want = (sel == REG_TIMEOUT) ? board.limit_ms : {31'b0, board.clock_sel};
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.compare(sel == REG_TIMEOUT ? "timeout_limit" : "clock_mode", want, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // One run of the log: a start, then mostly well-formed polls whose time
  // moves forward by up to step_max, with trace reads mixed in and the
  // occasional stray start, stop or poll at a wild time.
  task automatic run_session(input int n_items, input int unsigned step_max);
    logic [31:0] now_cur;
    logic [31:0] tick_cur;
    logic [31:0] tick_next;
    logic [10:0] frame_cur;
    logic [10:0] frame_next;
    logic [5:0]  idx;
    int unsigned pick;
    int unsigned flavour;
    now_cur   = $urandom;
    tick_cur  = $urandom;
    frame_cur = 11'($urandom_range(2047));
    send_item(REQ_START, now_cur, rnd_frame(), $urandom, rnd_frame(), $urandom, rnd_index());
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        now_cur = now_cur + $urandom_range(step_max);
        flavour = $urandom_range(99);
        if (flavour < 15) tick_next = tick_cur;
        else if (flavour < 18) tick_next = '0;
        else tick_next = $urandom;
        // A quarter of the polls see the frame number move on during capture.
        frame_next = ($urandom_range(3) == 0) ? frame_cur + 11'd1 : frame_cur;
        send_item(REQ_POLL, now_cur, frame_cur, tick_next, frame_next, $urandom,
                  rnd_index());
        frame_cur = frame_next;
        tick_cur  = tick_next;
      end else if (pick < 90) begin
        if (board.records != 0 && $urandom_range(3) != 0) begin
          idx = 6'($urandom_range(int'(board.records) - 1));
        end else begin
          idx = rnd_index();
        end
        send_item(REQ_READ, $urandom, rnd_frame(), $urandom, rnd_frame(), $urandom, idx);
      end else if (pick < 94) begin
        // A start while running is refused, so the time base only moves on
        // when the start is going to be taken.
        if (board.run_phase != PH_RUNNING) now_cur = $urandom;
        send_item(REQ_START, board.run_phase != PH_RUNNING ? now_cur : $urandom,
                  rnd_frame(), $urandom, rnd_frame(), $urandom, rnd_index());
      end else if (pick < 96) begin
        send_item(REQ_STOP, $urandom, rnd_frame(), $urandom, rnd_frame(), $urandom,
                  rnd_index());
      end else if (pick < 99) begin
        send_item(REQ_POLL, now_cur, rnd_frame(), $urandom, rnd_frame(), $urandom,
                  rnd_index());
      end else begin
        send_item(REQ_POLL, $urandom, rnd_frame(), $urandom, rnd_frame(), $urandom,
                  rnd_index());
      end
      // Now and then the sender waits for the pipeline to empty completely.
      if ($urandom_range(99) == 0) wait_drained();
    end
    // A trailing request after the run, which is often ignored by then.
    send_item($urandom_range(1) ? REQ_STOP : REQ_READ, $urandom, rnd_frame(), $urandom,
              rnd_frame(), $urandom, rnd_index());
  endtask

  // Runs random sessions until the phase has offered about quota items.
  task automatic run_phase_items(input int quota, input int unsigned step_max,
                                 input int first_len);
    int sent;
    int len;
    sent = 0;
    len  = first_len;
    while (sent < quota) begin
      run_session(len, step_max);
      sent = sent + len + 2;
      len  = $urandom_range(30, 110);
    end
  endtask

  localparam logic [31:0] WRAP_BASE = 32'hFFFF_FF00;

  initial begin
    board = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed checks under the reset register values (limit of 1000 ms).
    // Requests other than start have no effect before any run has begun.
    send_item(REQ_POLL, 32'd7, 11'd2047, 32'hFFFF_FFFF, 11'd0, 32'hFFFF_FFFF, 6'd63);
    send_item(REQ_STOP, 32'hFFFF_FFFF, 11'd0, 32'd0, 11'd2047, 32'd0, 6'd0);
    send_item(REQ_READ, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    // The run begins just short of the point where the millisecond time wraps.
    send_item(REQ_START, WRAP_BASE, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_START, 32'd5, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    // A zero first capture is a duplicate; the frames differ, so it still
    // counts as a crossing.
    send_item(REQ_POLL, WRAP_BASE + 32'd10, 11'd0, 32'd0, 11'd2047, 32'd1, 6'd0);
    send_item(REQ_POLL, WRAP_BASE + 32'd300, 11'd2047, 32'hFFFF_FFFF, 11'd2047,
              32'hFFFF_FFFF, 6'd0);
    send_item(REQ_POLL, WRAP_BASE + 32'd301, 11'd5, 32'hFFFF_FFFF, 11'd6, 32'd0, 6'd0);
    // Once a capture has been seen, a zero value is an ordinary new record.
    send_item(REQ_POLL, WRAP_BASE + 32'd302, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_READ, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_READ, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd1);
    send_item(REQ_READ, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd2);
    send_item(REQ_READ, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd63);
    // One millisecond short of the limit passes; the limit itself fails.
    send_item(REQ_POLL, WRAP_BASE + 32'd999, 11'd1, 32'd2, 11'd2, 32'd3, 6'd0);
    send_item(REQ_POLL, WRAP_BASE + 32'd1000, 11'd4, 32'd5, 11'd4, 32'd6, 6'd0);
    send_item(REQ_POLL, WRAP_BASE + 32'd1001, 11'd4, 32'd9, 11'd4, 32'd6, 6'd0);
    send_item(REQ_STOP, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_READ, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd2);
    // A fresh start from the failed phase, stopped at once with nothing stored.
    send_item(REQ_START, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_STOP, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_READ, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);

    // With a zero limit every poll of a run times out at once.
    wait_drained();
    program_reg(REG_TIMEOUT, 32'd0);
    program_reg(REG_CLOCK, 32'd1);
    send_item(REQ_START, 32'd100, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_POLL, 32'd100, 11'd3, 32'd8, 11'd3, 32'd8, 6'd0);

    // Largest limit: time running backwards gives a huge elapsed value that
    // still passes, and only the all-ones value reaches the limit.
    wait_drained();
    program_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    program_reg(REG_CLOCK, 32'd0);
    send_item(REQ_START, 32'd100, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_POLL, 32'd50, 11'd9, 32'd7, 11'd10, 32'd11, 6'd0);
    send_item(REQ_POLL, 32'd99, 11'd9, 32'd8, 11'd9, 32'd11, 6'd0);

    // A limit of one: only a poll at the start time itself gets through.
    wait_drained();
    program_reg(REG_TIMEOUT, 32'd1);
    send_item(REQ_START, 32'd7, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    send_item(REQ_POLL, 32'd7, 11'd1, 32'd9, 11'd1, 32'd1, 6'd0);
    send_item(REQ_POLL, 32'd8, 11'd1, 32'd10, 11'd1, 32'd1, 6'd0);

    // A fresh capture on every poll fills the record store and the run is
    // done; a poll after that is ignored, and the last entry reads back.
    wait_drained();
    program_reg(REG_TIMEOUT, TIMEOUT_RESET);
    send_item(REQ_START, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd0);
    for (int k = 0; k < DEPTH; k++) begin
      send_item(REQ_POLL, 32'(k), 11'(k), 32'(k + 1), 11'(k | 1), 32'(k), 6'd0);
    end
    send_item(REQ_POLL, 32'd70, 11'd1, 32'd99, 11'd2, 32'd5, 6'd0);
    send_item(REQ_READ, 32'd0, 11'd0, 32'd0, 11'd0, 32'd0, 6'd63);

    // Random phase with a light sender and a heavily stalling receiver; the
    // first run is long.
    run_phase_items(120, 12, 120);

    // Roles swapped, the widest limit and arbitrary steps in time.
    wait_drained();
    send_idle_pct = 54;
    recv_idle_pct = 6;
    program_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    program_reg(REG_CLOCK, 32'd1);
    run_phase_items(120, 32'hFFFF_FFFF, 110);

    // No idling at all, with a limit that runs often hit before they fill.
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_reg(REG_TIMEOUT, 32'd600);
    program_reg(REG_CLOCK, 32'd0);
    run_phase_items(120, 20, 90);

    wait_drained();
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_frame_timestamp_capture_log_top passed");
    end else begin
      $display("tb_frame_timestamp_capture_log_top failed");
    end
    $finish;
  end

  // A correct run ends far sooner than this.
  initial begin
    #20_000_000;
    $display("tb_frame_timestamp_capture_log_top failed");
    $finish;
  end

endmodule

FILE: frame_timestamp_capture_log_top.f
hdl/ftcl_pkg.sv
hdl/ftcl_store.sv
hdl/ftcl_ctrl.sv
hdl/ftcl_out.sv
hdl/frame_timestamp_capture_log_top.sv
hdl/ftcl_checker.sv
test/tb_frame_timestamp_capture_log_top.sv
